>>> design/scale_key_quantizer_macros.svh
// assertion macros for the scale key quantizer
`ifndef SCALE_KEY_QUANTIZER_MACROS_SVH
`define SCALE_KEY_QUANTIZER_MACROS_SVH

// same-cycle implication
`define SKQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("skq same-cycle check failed");

// next-cycle implication
`define SKQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("skq next-cycle check failed");

// delayed implication
`define SKQ_ASSERT_DELAY2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("skq two-cycle check failed");

`endif

>>> design/skq_pkg.sv
// shared types, constants and helper functions of the scale key quantizer
package skq_pkg;

    localparam int NUM_CLASSES    = 12;
    localparam int CLASS_BITS     = 4;
    localparam int KEY_BITS       = 7;
    localparam int LENGTH_BITS    = 16;
    localparam int ERR_BITS       = 32;
    localparam int STEP_BITS      = 8;
    localparam int MODE_BITS      = 4;
    localparam int POS_BITS       = 12;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 8;

    localparam logic [NUM_CLASSES-1:0] MAJOR_SHAPE = 12'b1010_1011_0101;

    localparam logic [MODE_BITS-1:0] MODE_ROT_MAX   = 4'd11;
    localparam logic [MODE_BITS-1:0] MODE_SELECTED  = 4'd13;
    localparam logic [MODE_BITS-1:0] MODE_CHROMATIC = 4'd12;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCALE_MODE      = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRANSPOSE_STEPS = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIT_INTO_SCALE  = 2'd2;

    localparam logic [KEY_BITS-1:0] KEY_MAX = 7'd127;
    localparam logic [ERR_BITS-1:0] ERR_MAX = '1;

    typedef logic [NUM_CLASSES-1:0] mask_t;
    typedef logic [CLASS_BITS-1:0] class_t;
    typedef logic signed [POS_BITS-1:0] pos_t;

    typedef enum logic [1:0] {
        OP_OBSERVE = 2'd0,
        OP_ANALYZE = 2'd1,
        OP_MAP     = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OBS_READ,
        ST_OBS_WRITE,
        ST_AN_READ,
        ST_AN_WAIT,
        ST_MAP_WAIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_FIT,
        MS_ALIGN,
        MS_WALK
    } map_state_t;

    typedef enum logic {
        AS_IDLE,
        AS_SCAN
    } an_state_t;

    typedef struct packed {
        op_t                    opcode;
        logic [KEY_BITS-1:0]    note_key;
        logic [LENGTH_BITS-1:0] note_length;
    } in_word_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]   mapped_key;
        logic                  key_clipped;
        logic [CLASS_BITS-1:0] best_rotation;
        logic [ERR_BITS-1:0]   best_error;
    } out_word_t;

    typedef struct packed {
        logic                        go;
        logic                        fit;
        logic [KEY_BITS-1:0]         note_key;
        logic signed [STEP_BITS-1:0] steps;
        mask_t                       mask;
    } map_req_t;

    typedef struct packed {
        logic                done;
        logic [KEY_BITS-1:0] mapped_key;
        logic                key_clipped;
    } map_rsp_t;

    typedef struct packed {
        logic   valid;
        class_t cls;
    } an_feed_t;

    typedef struct packed {
        logic                done;
        class_t              best_rotation;
        logic [ERR_BITS-1:0] best_error;
    } an_rsp_t;

    // value below 24 folded into 0..11
    function automatic class_t wrap12(input logic [4:0] v);
        logic [4:0] r;
        r = (v >= 5'd12) ? v - 5'd12 : v;
        return r[CLASS_BITS-1:0];
    endfunction

    // remainder by twelve through a reciprocal multiply, valid below 512
    function automatic class_t mod12(input logic [8:0] v);
        logic [17:0] prod;
        logic [8:0]  q;
        logic [8:0]  rem;
        prod = 18'(v) * 18'd171;
        q    = {2'b00, prod[17:11]};
        rem  = v - q * 9'd12;
        return rem[CLASS_BITS-1:0];
    endfunction

    function automatic class_t class_inc(input class_t c);
        return (c == class_t'(NUM_CLASSES - 1)) ? '0 : c + class_t'(1);
    endfunction

    function automatic class_t class_dec(input class_t c);
        return (c == '0) ? class_t'(NUM_CLASSES - 1) : c - class_t'(1);
    endfunction

    // bit c of the result is bit (c - s) mod 12 of v
    function automatic mask_t rotl12(input mask_t v, input class_t s);
        logic [2*NUM_CLASSES-1:0] w;
        w = {v, v} << s;
        return w[2*NUM_CLASSES-1:NUM_CLASSES];
    endfunction

    // lowest j with mask set at class c + j
    function automatic class_t dist_up(input mask_t m, input class_t c);
        class_t d;
        d = '0;
        for (int j = NUM_CLASSES - 1; j >= 0; j--)
        begin
            if (m[wrap12(5'(c) + 5'(j))])
            begin
                d = class_t'(j);
            end
        end
        return d;
    endfunction

    // lowest j with mask set at class c - j
    function automatic class_t dist_dn(input mask_t m, input class_t c);
        class_t d;
        d = '0;
        for (int j = NUM_CLASSES - 1; j >= 0; j--)
        begin
            if (m[wrap12(5'(c) + 5'd12 - 5'(j))])
            begin
                d = class_t'(j);
            end
        end
        return d;
    endfunction

endpackage

>>> design/skq_ram.sv
// generic single-port-write ram with registered read
module skq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 12
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/skq_analyze.sv
// key analysis: per-rotation out-of-scale sums and a serial minimum search
module skq_analyze #(
    parameter int WEIGHT_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  skq_pkg::an_feed_t      feed,
    input  logic [WEIGHT_BITS-1:0] weight,
    output skq_pkg::an_rsp_t       rsp
);

    localparam int ACC_BITS = WEIGHT_BITS + 3;
    localparam int EXT_BITS = (ACC_BITS > skq_pkg::ERR_BITS) ? ACC_BITS : skq_pkg::ERR_BITS;
    localparam skq_pkg::class_t LAST_CLASS = skq_pkg::class_t'(skq_pkg::NUM_CLASSES - 1);

    skq_pkg::an_state_t state_reg, state_next;
    logic [ACC_BITS-1:0] acc_reg [skq_pkg::NUM_CLASSES];
    logic [ACC_BITS-1:0] acc_next [skq_pkg::NUM_CLASSES];
    skq_pkg::class_t     idx_reg, idx_next;
    logic [ACC_BITS-1:0] best_reg, best_next;
    skq_pkg::class_t     rot_reg, rot_next;
    skq_pkg::an_rsp_t    rsp_reg, rsp_next;

    skq_pkg::mask_t      rot_mask;
    logic [ACC_BITS-1:0] acc_base;
    logic [ACC_BITS-1:0] cand;
    logic                take;
    logic [EXT_BITS-1:0] sel_ext;

    // one lane per rotation, fed one class per cycle
    always_comb
    begin
        rot_mask = '0;
        acc_base = '0;
        for (int r = 0; r < skq_pkg::NUM_CLASSES; r++)
        begin
            rot_mask    = skq_pkg::rotl12(skq_pkg::MAJOR_SHAPE, skq_pkg::class_t'(r));
            acc_base    = (feed.cls == '0) ? '0 : acc_reg[r];
            acc_next[r] = acc_reg[r];
            if (feed.valid)
            begin
                acc_next[r] = rot_mask[feed.cls] ? acc_base : acc_base + ACC_BITS'(weight);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skq_pkg::AS_IDLE:
            begin
                if (feed.valid && feed.cls == LAST_CLASS)
                begin
                    state_next = skq_pkg::AS_SCAN;
                end
            end
            skq_pkg::AS_SCAN:
            begin
                if (idx_reg == LAST_CLASS)
                begin
                    state_next = skq_pkg::AS_IDLE;
                end
            end
            default:
            begin
                state_next = skq_pkg::AS_IDLE;
            end
        endcase
    end

    // first rotation wins on ties
    always_comb
    begin
        cand      = acc_reg[idx_reg];
        take      = (idx_reg == '0) || (cand < best_reg);
        best_next = take ? cand : best_reg;
        rot_next  = take ? idx_reg : rot_reg;
        sel_ext   = EXT_BITS'(best_next);
        idx_next  = '0;
        rsp_next  = '0;
        if (state_reg == skq_pkg::AS_SCAN)
        begin
            if (idx_reg == LAST_CLASS)
            begin
                rsp_next.done          = 1'b1;
                rsp_next.best_rotation = rot_next;
                rsp_next.best_error    = (sel_ext > EXT_BITS'(skq_pkg::ERR_MAX)) ?
                                         skq_pkg::ERR_MAX : sel_ext[skq_pkg::ERR_BITS-1:0];
            end
            else
            begin
                idx_next = idx_reg + skq_pkg::class_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skq_pkg::AS_IDLE;
            idx_reg   <= '0;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        best_reg <= best_next;
        rot_reg  <= rot_next;
    end

    assign rsp = rsp_reg;

endmodule

>>> design/skq_map.sv
// key mapping: nearest-member search or scale-step walk, then clipping
module skq_map (
    input  logic              clk,
    input  logic              rst_n,
    input  skq_pkg::map_req_t req,
    output skq_pkg::map_rsp_t rsp
);

    skq_pkg::map_state_t state_reg, state_next;
    skq_pkg::mask_t      mask_reg, mask_next;
    logic signed [skq_pkg::STEP_BITS-1:0] steps_reg, steps_next;
    skq_pkg::pos_t       pos_reg, pos_next;
    skq_pkg::class_t     cls_reg, cls_next;
    skq_pkg::class_t     off_reg, off_next;
    skq_pkg::class_t     n_reg, n_next;
    skq_pkg::class_t     up_c_reg, up_c_next;
    skq_pkg::class_t     dn_c_reg, dn_c_next;
    logic                down_reg, down_next;
    skq_pkg::map_rsp_t   rsp_reg, rsp_next;

    logic signed [9:0] base;
    logic [9:0]        biased;
    skq_pkg::pos_t     cand_pos;
    skq_pkg::class_t   cand_c;
    skq_pkg::class_t   off_w;
    logic [4:0]        d;
    skq_pkg::pos_t     fin_pos;
    logic              fin;

    assign base   = $signed({3'b000, req.note_key}) + $signed({{2{req.steps[7]}}, req.steps});
    assign biased = base + 10'sd132;

    // candidates in the order k, k+1, k-1, k+2, k-2 ...
    assign cand_pos = down_reg ? pos_reg - $signed({8'b0, n_reg}) : pos_reg + $signed({8'b0, n_reg});
    assign cand_c   = down_reg ? dn_c_reg : up_c_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skq_pkg::MS_IDLE:
            begin
                if (req.go)
                begin
                    state_next = req.fit ? skq_pkg::MS_FIT : skq_pkg::MS_ALIGN;
                end
            end
            skq_pkg::MS_FIT:
            begin
                if (mask_reg[cand_c])
                begin
                    state_next = skq_pkg::MS_IDLE;
                end
            end
            skq_pkg::MS_ALIGN:
            begin
                state_next = skq_pkg::MS_WALK;
            end
            skq_pkg::MS_WALK:
            begin
                if (steps_reg == '0)
                begin
                    state_next = skq_pkg::MS_IDLE;
                end
            end
            default:
            begin
                state_next = skq_pkg::MS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mask_next  = mask_reg;
        steps_next = steps_reg;
        pos_next   = pos_reg;
        cls_next   = cls_reg;
        off_next   = off_reg;
        n_next     = n_reg;
        up_c_next  = up_c_reg;
        dn_c_next  = dn_c_reg;
        down_next  = down_reg;
        off_w      = '0;
        d          = '0;
        fin        = 1'b0;
        fin_pos    = pos_reg;
        case (state_reg)
            skq_pkg::MS_IDLE:
            begin
                if (req.go)
                begin
                    mask_next  = req.mask;
                    steps_next = req.steps;
                    if (req.fit)
                    begin
                        pos_next  = {{2{base[9]}}, base};
                        up_c_next = skq_pkg::mod12(biased[8:0]);
                        dn_c_next = skq_pkg::mod12(biased[8:0]);
                        n_next    = '0;
                        down_next = 1'b1;
                    end
                    else
                    begin
                        pos_next = $signed({5'b00000, req.note_key});
                        cls_next = skq_pkg::mod12({2'b00, req.note_key});
                    end
                end
            end
            skq_pkg::MS_FIT:
            begin
                if (mask_reg[cand_c])
                begin
                    fin     = 1'b1;
                    fin_pos = cand_pos;
                end
                else if (down_reg)
                begin
                    n_next    = n_reg + skq_pkg::class_t'(1);
                    up_c_next = skq_pkg::class_inc(up_c_reg);
                    down_next = 1'b0;
                end
                else
                begin
                    dn_c_next = skq_pkg::class_dec(dn_c_reg);
                    down_next = 1'b1;
                end
            end
            skq_pkg::MS_ALIGN:
            begin
                // off-scale key starts at the next member at or above it
                off_w    = skq_pkg::dist_up(mask_reg, cls_reg);
                pos_next = pos_reg + $signed({8'b0, off_w});
                cls_next = skq_pkg::wrap12(5'(cls_reg) + 5'(off_w));
                off_next = off_w;
            end
            skq_pkg::MS_WALK:
            begin
                if (steps_reg == '0)
                begin
                    fin     = 1'b1;
                    fin_pos = pos_reg - $signed({8'b0, off_reg});
                end
                else if (!steps_reg[skq_pkg::STEP_BITS-1])
                begin
                    d = 5'(skq_pkg::dist_up(mask_reg, skq_pkg::class_inc(cls_reg))) + 5'd1;
                    pos_next   = pos_reg + $signed({7'b0, d});
                    cls_next   = skq_pkg::wrap12(5'(cls_reg) + d);
                    steps_next = steps_reg - 8'sd1;
                end
                else
                begin
                    d = 5'(skq_pkg::dist_dn(mask_reg, skq_pkg::class_dec(cls_reg))) + 5'd1;
                    pos_next   = pos_reg - $signed({7'b0, d});
                    cls_next   = skq_pkg::wrap12(5'(cls_reg) + 5'd12 - d);
                    steps_next = steps_reg + 8'sd1;
                end
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_next      = '0;
        rsp_next.done = fin;
        if (fin_pos < 12'sd0)
        begin
            rsp_next.mapped_key  = '0;
            rsp_next.key_clipped = 1'b1;
        end
        else if (fin_pos > $signed({5'b00000, skq_pkg::KEY_MAX}))
        begin
            rsp_next.mapped_key  = skq_pkg::KEY_MAX;
            rsp_next.key_clipped = 1'b1;
        end
        else
        begin
            rsp_next.mapped_key = fin_pos[skq_pkg::KEY_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skq_pkg::MS_IDLE;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg  <= mask_next;
        steps_reg <= steps_next;
        pos_reg   <= pos_next;
        cls_reg   <= cls_next;
        off_reg   <= off_next;
        n_reg     <= n_next;
        up_c_reg  <= up_c_next;
        dn_c_reg  <= dn_c_next;
        down_reg  <= down_next;
    end

    assign rsp = rsp_reg;

endmodule

>>> design/scale_key_quantizer.sv
// top level of the scale key quantizer: control, configuration and weight memory
//
// usage
//   a command word (opcode, note_key, note_length) is taken on a clock edge with
//   start high and busy low; busy stays high until the command has finished.
//   analyze and map give one result word on result, marked by done for one
//   cycle; observe and clear give none. done cannot be held off.
//   configuration is written through cfg_we, cfg_index and cfg_data while idle.
// steps of each command after it is accepted
//   clear: on acceptance. observe: read, then saturating add written back to ram.
//   analyze: the twelve ram reads, then the twelve-step minimum scan.
//   map, fit: one candidate key per cycle, at most twelve candidates.
//   map, walk: an align step, then one scale member per cycle.
//   the next command is taken at the edge that takes the result.
// reset
//   histogram empty (occupancy bits cleared at once, the ram is not swept),
//   scale_mode chromatic, transpose_steps 0, walk mode.
module scale_key_quantizer #(
    parameter int WEIGHT_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  skq_pkg::in_word_t                     cmd,
    output logic                                  done,
    output skq_pkg::out_word_t                    result,
    input  logic                                  cfg_we,
    input  logic [skq_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [skq_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    `include "scale_key_quantizer_macros.svh"

    localparam int SUM_BITS = ((WEIGHT_BITS > skq_pkg::LENGTH_BITS) ?
                               WEIGHT_BITS : skq_pkg::LENGTH_BITS) + 1;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;
    localparam skq_pkg::class_t LAST_CLASS = skq_pkg::class_t'(skq_pkg::NUM_CLASSES - 1);

    skq_pkg::ctrl_state_t state_reg, state_next;
    logic [skq_pkg::MODE_BITS-1:0]        scale_mode_reg;
    logic signed [skq_pkg::STEP_BITS-1:0] transpose_reg;
    logic                                 fit_reg;
    skq_pkg::mask_t                       nz_reg;
    skq_pkg::class_t                      cls_reg;
    logic [skq_pkg::LENGTH_BITS-1:0]      len_reg;
    skq_pkg::class_t                      cnt_reg;
    logic                                 rd_pend_reg;
    skq_pkg::class_t                      rd_cls_reg;
    logic                                 done_reg, done_next;
    skq_pkg::out_word_t                   result_reg, result_next;

    logic                   accept;
    logic                   mem_we;
    logic                   mem_re;
    skq_pkg::class_t        mem_raddr;
    logic [WEIGHT_BITS-1:0] mem_rdata;
    logic [WEIGHT_BITS-1:0] cur_w;
    logic [SUM_BITS-1:0]    sum_w;
    logic [WEIGHT_BITS-1:0] wdata_w;
    skq_pkg::mask_t         scale_mask;
    skq_pkg::an_feed_t      feed;
    logic [WEIGHT_BITS-1:0] feed_weight;
    skq_pkg::an_rsp_t       an_rsp;
    skq_pkg::map_req_t      map_req;
    skq_pkg::map_rsp_t      map_rsp;
    logic                   in_wait;
    logic                   obs_accept;
    logic                   clr_accept;

    assign busy   = (state_reg != skq_pkg::ST_IDLE);
    assign accept = start && !busy;

    // scale mask from mode and occupancy
    always_comb
    begin
        case (scale_mode_reg) inside
            [4'd0:skq_pkg::MODE_ROT_MAX]:
            begin
                scale_mask = skq_pkg::rotl12(skq_pkg::MAJOR_SHAPE,
                                             skq_pkg::class_t'(scale_mode_reg));
            end
            skq_pkg::MODE_SELECTED:
            begin
                scale_mask = (nz_reg == '0) ? skq_pkg::mask_t'(1) : nz_reg;
            end
            default:
            begin
                scale_mask = '1;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.opcode)
                        skq_pkg::OP_OBSERVE: state_next = skq_pkg::ST_OBS_READ;
                        skq_pkg::OP_ANALYZE: state_next = skq_pkg::ST_AN_READ;
                        skq_pkg::OP_MAP:     state_next = skq_pkg::ST_MAP_WAIT;
                        default:             state_next = skq_pkg::ST_IDLE;
                    endcase
                end
            end
            skq_pkg::ST_OBS_READ:
            begin
                state_next = skq_pkg::ST_OBS_WRITE;
            end
            skq_pkg::ST_OBS_WRITE:
            begin
                state_next = skq_pkg::ST_IDLE;
            end
            skq_pkg::ST_AN_READ:
            begin
                if (cnt_reg == LAST_CLASS)
                begin
                    state_next = skq_pkg::ST_AN_WAIT;
                end
            end
            skq_pkg::ST_AN_WAIT:
            begin
                if (an_rsp.done)
                begin
                    state_next = skq_pkg::ST_IDLE;
                end
            end
            skq_pkg::ST_MAP_WAIT:
            begin
                if (map_rsp.done)
                begin
                    state_next = skq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = skq_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_we    = (state_reg == skq_pkg::ST_OBS_WRITE);
        mem_re    = (state_reg == skq_pkg::ST_OBS_READ) || (state_reg == skq_pkg::ST_AN_READ);
        mem_raddr = (state_reg == skq_pkg::ST_AN_READ) ? cnt_reg : cls_reg;
    end

    // an entry with no weight since the last clear reads as zero
    assign cur_w   = nz_reg[cls_reg] ? mem_rdata : '0;
    assign sum_w   = SUM_BITS'(cur_w) + SUM_BITS'(len_reg);
    assign wdata_w = (sum_w > SUM_BITS'(WEIGHT_MAX)) ? WEIGHT_MAX : sum_w[WEIGHT_BITS-1:0];

    assign feed.valid  = rd_pend_reg;
    assign feed.cls    = rd_cls_reg;
    assign feed_weight = nz_reg[rd_cls_reg] ? mem_rdata : '0;

    assign map_req.go       = accept && (cmd.opcode == skq_pkg::OP_MAP);
    assign map_req.fit      = fit_reg;
    assign map_req.note_key = cmd.note_key;
    assign map_req.steps    = transpose_reg;
    assign map_req.mask     = scale_mask;

    always_comb
    begin
        done_next   = an_rsp.done || map_rsp.done;
        result_next = '0;
        if (an_rsp.done)
        begin
            result_next.best_rotation = an_rsp.best_rotation;
            result_next.best_error    = an_rsp.best_error;
        end
        else
        begin
            result_next.mapped_key  = map_rsp.mapped_key;
            result_next.key_clipped = map_rsp.key_clipped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= skq_pkg::ST_IDLE;
            scale_mode_reg <= skq_pkg::MODE_CHROMATIC;
            transpose_reg  <= '0;
            fit_reg        <= 1'b0;
            nz_reg         <= '0;
            cnt_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            rd_cls_reg     <= '0;
            cls_reg        <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            rd_pend_reg <= (state_reg == skq_pkg::ST_AN_READ);
            rd_cls_reg  <= cnt_reg;
            if (cfg_we)
            begin
                case (cfg_index)
                    skq_pkg::CFG_SCALE_MODE:      scale_mode_reg <= cfg_data[skq_pkg::MODE_BITS-1:0];
                    skq_pkg::CFG_TRANSPOSE_STEPS: transpose_reg  <= $signed(cfg_data);
                    skq_pkg::CFG_FIT_INTO_SCALE:  fit_reg        <= cfg_data[0];
                    default:                      fit_reg        <= fit_reg;
                endcase
            end
            if (accept)
            begin
                cls_reg <= skq_pkg::mod12({2'b00, cmd.note_key});
                cnt_reg <= '0;
                if (cmd.opcode == skq_pkg::OP_CLEAR)
                begin
                    nz_reg <= '0;
                end
            end
            else if (state_reg == skq_pkg::ST_AN_READ)
            begin
                cnt_reg <= cnt_reg + skq_pkg::class_t'(1);
            end
            if (state_reg == skq_pkg::ST_OBS_WRITE)
            begin
                nz_reg[cls_reg] <= nz_reg[cls_reg] || (len_reg != '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            len_reg <= cmd.note_length;
        end
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    skq_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (skq_pkg::NUM_CLASSES)
    ) u_weight_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (cls_reg),
        .wdata (wdata_w),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    skq_analyze #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_analyze (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed),
        .weight (feed_weight),
        .rsp    (an_rsp)
    );

    skq_map u_map (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (map_req),
        .rsp   (map_rsp)
    );

    assign in_wait    = (state_reg == skq_pkg::ST_AN_WAIT) || (state_reg == skq_pkg::ST_MAP_WAIT);
    assign obs_accept = accept && (cmd.opcode == skq_pkg::OP_OBSERVE);
    assign clr_accept = accept && (cmd.opcode == skq_pkg::OP_CLEAR);

    `SKQ_ASSERT_IMPLIES(a_done_from_wait, clk, rst_n, done_reg, $past(in_wait))
    `SKQ_ASSERT_DELAY2(a_observe_writes_back, clk, rst_n, obs_accept, mem_we)
    `SKQ_ASSERT_NEXT(a_clear_empties, clk, rst_n, clr_accept, nz_reg == '0)

endmodule

>>> bench/scale_key_quantizer_tb.sv
// testbench for the scale key quantizer: directed and random commands checked by a predictor
`timescale 1ns / 1ps

module scale_key_quantizer_tb;

    import skq_pkg::*;

    localparam int WEIGHT_BITS = 32;
    localparam int SETTLE_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 50;
    localparam int HEAVY_ITEMS = 8;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam bit [NUM_CLASSES-1:0] MAJOR_STEPS = 12'b1010_1011_0101;

    class scale_checker;
        bit [WEIGHT_BITS-1:0] weight [NUM_CLASSES];
        bit [MODE_BITS-1:0] mode;
        int steps;
        bit fit;
        out_word_t awaited_words [$];
        int errors;

        function new();
            foreach (weight[i])
            begin
                weight[i] = '0;
            end
            mode = MODE_CHROMATIC;
            steps = 0;
            fit = 1'b0;
            errors = 0;
        endfunction

        function int pending();
            return awaited_words.size();
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_SCALE_MODE:      mode = data[MODE_BITS-1:0];
                CFG_TRANSPOSE_STEPS: steps = int'($signed(data));
                CFG_FIT_INTO_SCALE:  fit = data[0];
                default:             ;
            endcase
        endfunction

        function int pitch_class(int k);
            int r;
            r = k % NUM_CLASSES;
            return (r < 0) ? r + NUM_CLASSES : r;
        endfunction

        function bit [NUM_CLASSES-1:0] major_at(int rot);
            bit [NUM_CLASSES-1:0] m;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                m[(i + rot) % NUM_CLASSES] = MAJOR_STEPS[i];
            end
            return m;
        endfunction

        function bit [NUM_CLASSES-1:0] scale_mask();
            bit [NUM_CLASSES-1:0] m;
            if (mode <= MODE_ROT_MAX)
            begin
                m = major_at(int'(mode));
            end
            else if (mode == MODE_SELECTED)
            begin
                for (int i = 0; i < NUM_CLASSES; i++)
                begin
                    m[i] = (weight[i] != '0);
                end
                if (m == '0)
                begin
                    m[0] = 1'b1;
                end
            end
            else
            begin
                m = '1;
            end
            return m;
        endfunction

        // nearest member, trying +1, -1, +2, -2 and so on
        function int fit_key(int k, bit [NUM_CLASSES-1:0] m);
            int off;
            off = 0;
            while (!m[pitch_class(k)] && off < 2 * NUM_CLASSES + 2)
            begin
                off++;
                if (off % 2 == 1)
                begin
                    k += off;
                end
                else
                begin
                    k -= off;
                end
            end
            return k;
        endfunction

        function int walk_key(int k, int s, bit [NUM_CLASSES-1:0] m);
            int off;
            off = 0;
            while (!m[pitch_class(k)] && off < NUM_CLASSES)
            begin
                k++;
                off++;
            end
            while (s > 0)
            begin
                do
                begin
                    k++;
                end
                while (!m[pitch_class(k)]);
                s--;
            end
            while (s < 0)
            begin
                do
                begin
                    k--;
                end
                while (!m[pitch_class(k)]);
                s++;
            end
            return k - off;
        endfunction

        function out_word_t predict_analyze();
            out_word_t w;
            longint unsigned best;
            longint unsigned err;
            int best_rot;
            bit [NUM_CLASSES-1:0] m;
            best = 0;
            best_rot = 0;
            for (int r = 0; r < NUM_CLASSES; r++)
            begin
                m = major_at(r);
                err = 0;
                for (int i = 0; i < NUM_CLASSES; i++)
                begin
                    if (!m[i])
                    begin
                        err += longint'(weight[i]);
                    end
                end
                if (r == 0 || err < best)
                begin
                    best = err;
                    best_rot = r;
                end
            end
            w = '0;
            w.best_rotation = CLASS_BITS'(best_rot);
            w.best_error = (best > longint'(ERR_MAX)) ? ERR_MAX : best[ERR_BITS-1:0];
            return w;
        endfunction

        function out_word_t predict_map(int key);
            out_word_t w;
            bit [NUM_CLASSES-1:0] m;
            int k;
            m = scale_mask();
            w = '0;
            if (fit)
            begin
                k = fit_key(key + steps, m);
            end
            else
            begin
                k = walk_key(key, steps, m);
            end
            if (k < 0)
            begin
                k = 0;
                w.key_clipped = 1'b1;
            end
            else if (k > int'(KEY_MAX))
            begin
                k = int'(KEY_MAX);
                w.key_clipped = 1'b1;
            end
            w.mapped_key = KEY_BITS'(k);
            return w;
        endfunction

        function void note_command(in_word_t w);
            int c;
            bit [WEIGHT_BITS:0] total;
            case (w.opcode)
                OP_OBSERVE:
                begin
                    c = pitch_class(int'(w.note_key));
                    total = weight[c] + w.note_length;
                    weight[c] = total[WEIGHT_BITS] ? '1 : total[WEIGHT_BITS-1:0];
                end
                OP_CLEAR:
                begin
                    foreach (weight[i])
                    begin
                        weight[i] = '0;
                    end
                end
                OP_ANALYZE: awaited_words.push_back(predict_analyze());
                OP_MAP:     awaited_words.push_back(predict_map(int'(w.note_key)));
                default:    ;
            endcase
        endfunction

        task check_word(out_word_t got);
            out_word_t want;
            if (awaited_words.size() == 0)
            begin
                report("result word with nothing outstanding");
                return;
            end
            want = awaited_words.pop_front();
            if (got.mapped_key !== want.mapped_key)
            begin
                report($sformatf("mapped_key %0d, want %0d", got.mapped_key, want.mapped_key));
            end
            if (got.key_clipped !== want.key_clipped)
            begin
                report($sformatf("key_clipped %0b, want %0b", got.key_clipped, want.key_clipped));
            end
            if (got.best_rotation !== want.best_rotation)
            begin
                report($sformatf("best_rotation %0d, want %0d",
                                 got.best_rotation, want.best_rotation));
            end
            if (got.best_error !== want.best_error)
            begin
                report($sformatf("best_error %0h, want %0h", got.best_error, want.best_error));
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_word_t cmd;
    logic done;
    out_word_t result;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    scale_checker sb;
    bit idle_on;
    int unsigned cycle_count = 0;

    scale_key_quantizer #(
        .WEIGHT_BITS(WEIGHT_BITS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // results first: a word out at an edge always belongs to an earlier command
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && sb != null)
        begin
            if (done !== 1'b0)
            begin
                sb.check_word(result);
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                sb.note_command(cmd);
            end
            if (cfg_we === 1'b1)
            begin
                sb.write_reg(cfg_index, cfg_data);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic in_word_t make_cmd(op_t op, int key, int len);
        in_word_t w;
        w.opcode = op;
        w.note_key = KEY_BITS'(key);
        w.note_length = LENGTH_BITS'(len);
        return w;
    endfunction

    function automatic in_word_t random_cmd();
        int pick;
        int key;
        int len;
        op_t op;
        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            op = OP_CLEAR;
        end
        else if (pick < 44)
        begin
            op = OP_OBSERVE;
        end
        else if (pick < 60)
        begin
            op = OP_ANALYZE;
        end
        else
        begin
            op = OP_MAP;
        end
        pick = $urandom_range(0, 9);
        key = (pick == 0) ? 0 : (pick == 1) ? 127 : $urandom_range(0, 127);
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            len = 0;
        end
        else if (pick == 1)
        begin
            len = 65535;
        end
        else if (pick < 5)
        begin
            len = $urandom_range(1, 64);
        end
        else
        begin
            len = $urandom_range(0, 65535);
        end
        return make_cmd(op, key, len);
    endfunction

    // entered and left at a falling edge; start is left high for the caller to decide
    task automatic send_cmd(in_word_t w);
        while (idle_on && $urandom_range(0, 99) < 18)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd <= w;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0 || busy !== 1'b0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic configure(bit [MODE_BITS-1:0] mode, bit signed [STEP_BITS-1:0] steps, bit fit);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= CFG_SCALE_MODE;
        cfg_data <= {4'($urandom), mode};
        @(negedge clk);
        cfg_index <= CFG_TRANSPOSE_STEPS;
        cfg_data <= steps;
        @(negedge clk);
        cfg_index <= CFG_FIT_INTO_SCALE;
        cfg_data <= {7'($urandom), fit};
        @(negedge clk);
        if ($urandom_range(0, 3) == 0)
        begin
            cfg_index <= CFG_SPARE;
            cfg_data <= 8'($urandom);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int modes [6];
        int steps_val;
        bit fit_val;
        bit [MODE_BITS-1:0] mode_val;
        modes = '{0, 11, 12, 13, 14, 15};
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_on = 1'b1;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty histogram, field extremes, every op, fit and walk, scale modes 0 and 11 to 15
        send_cmd(make_cmd(OP_ANALYZE, 0, 0));
        send_cmd(make_cmd(OP_MAP, 0, 65535));
        send_cmd(make_cmd(OP_MAP, 127, 0));
        send_cmd(make_cmd(OP_OBSERVE, 0, 65535));
        send_cmd(make_cmd(OP_OBSERVE, 127, 0));
        send_cmd(make_cmd(OP_OBSERVE, 85, 16'h5555));
        send_cmd(make_cmd(OP_OBSERVE, 42, 16'hAAAA));
        send_cmd(make_cmd(OP_ANALYZE, 127, 65535));
        send_cmd(make_cmd(OP_MAP, 85, 0));
        configure(MODE_SELECTED, 0, 1'b1);
        send_cmd(make_cmd(OP_MAP, 4, 0));
        send_cmd(make_cmd(OP_CLEAR, 127, 65535));
        send_cmd(make_cmd(OP_MAP, 50, 0));
        send_cmd(make_cmd(OP_ANALYZE, 0, 0));
        configure(4'd0, 8'sd127, 1'b0);
        send_cmd(make_cmd(OP_MAP, 0, 0));
        send_cmd(make_cmd(OP_MAP, 127, 0));
        send_cmd(make_cmd(OP_MAP, 1, 0));
        configure(MODE_ROT_MAX, -8'sd127, 1'b1);
        send_cmd(make_cmd(OP_MAP, 0, 0));
        send_cmd(make_cmd(OP_MAP, 127, 0));
        configure(4'd14, 8'sd5, 1'b0);
        send_cmd(make_cmd(OP_MAP, 60, 0));
        configure(4'd15, -8'sd1, 1'b0);
        send_cmd(make_cmd(OP_MAP, 3, 0));
        send_cmd(make_cmd(OP_MAP, 0, 0));

        // heavy weight on one class alone, back to back
        configure(MODE_SELECTED, -8'sd3, 1'b1);
        send_cmd(make_cmd(OP_CLEAR, 0, 0));
        idle_on = 1'b0;
        for (int i = 0; i < HEAVY_ITEMS; i++)
        begin
            send_cmd(make_cmd(OP_OBSERVE, 7 + 12 * $urandom_range(0, 9), 65535));
        end
        idle_on = 1'b1;
        send_cmd(make_cmd(OP_OBSERVE, 7, 1));
        send_cmd(make_cmd(OP_ANALYZE, 0, 0));
        send_cmd(make_cmd(OP_MAP, 64, 0));

        for (int p = 0; p < PHASES; p++)
        begin
            mode_val = (p < 6) ? MODE_BITS'(modes[p])
                     : (p % 3 == 0) ? MODE_SELECTED : MODE_BITS'($urandom_range(0, 15));
            case (p % 4)
                0:       steps_val = $urandom_range(0, 16) - 8;
                1:       steps_val = ((p / 4) % 2 == 0) ? 127 : -127;
                2:       steps_val = 0;
                default: steps_val = $urandom_range(0, 255) - 128;
            endcase
            fit_val = ((p / 4) % 2 == 1) ^ (p % 2 == 1);
            configure(mode_val, STEP_BITS'(steps_val), fit_val);
            idle_on = !(p >= 4 && p <= 6);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 3 && i == PHASE_ITEMS / 2)
                begin
                    drain();
                end
                send_cmd(random_cmd());
            end
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/skq_pkg.sv
design/skq_ram.sv
design/skq_analyze.sv
design/skq_map.sv
design/scale_key_quantizer.sv
bench/scale_key_quantizer_tb.sv
